FILE: rtl/ecct_pkg.sv
// ----------------------------------------------------------------------------
// ecct_pkg: shared types and constants for the camera trigger sequencer
// Event kinds, register indexes, reset values and divider constants.
// ----------------------------------------------------------------------------
`default_nettype none

package ecct_pkg;

    // Event kinds carried in s_tuser.
    typedef enum logic [2:0] {
        ACT_TIMER           = 3'd0,
        ACT_PRIMARY_END     = 3'd1,
        ACT_SECONDARY_END   = 3'd2,
        ACT_INIT            = 3'd3,
        ACT_INITIAL_TRIGGER = 3'd4
    } action_t;

    // Steps of the exposure-to-ticks conversion.
    typedef enum logic [2:0] {
        DIV_IDLE,
        DIV_PROD,
        DIV_PART,
        DIV_EST,
        DIV_CHECK,
        DIV_DONE
    } div_state_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_COMP_EN   = 2'd0;
    localparam logic [1:0] REG_PERIOD    = 2'd1;
    localparam logic [1:0] REG_TICK_RATE = 2'd2;
    localparam logic [1:0] REG_MAX_EXP   = 2'd3;

    localparam int CFG_W    = 27;
    localparam int PERIOD_W = 16;
    localparam int TPS_W    = 27;
    localparam int MAXEXP_W = 20;

    localparam logic                RST_COMP_EN   = 1'b1;
    localparam logic [PERIOD_W-1:0] RST_PERIOD    = 16'd50000;
    localparam logic [TPS_W-1:0]    RST_TICK_RATE = 27'd1000000;
    localparam logic [MAXEXP_W-1:0] RST_MAX_EXP   = 20'd49500;

    // Delay ticks = floor(exposure * rate / 2e6), with 2e6 = 2^7 * 15625.
    localparam int PROD_W    = MAXEXP_W + TPS_W;   // 47
    localparam int PRE_SHIFT = 7;
    localparam int X_W       = PROD_W - PRE_SHIFT; // 40
    localparam int HALF_W    = X_W / 2;            // 20
    localparam int DELAY_W   = 27;
    localparam logic [13:0]        DIV_ODD   = 14'd15625;
    // floor(2^40 / 15625)
    localparam logic [DELAY_W-1:0] DIV_RECIP = 27'd70368744;

endpackage

`default_nettype wire

FILE: rtl/exposure_compensated_camera_trigger.sv
// ----------------------------------------------------------------------------
// exposure_compensated_camera_trigger: camera trigger sequencer
// Turns timer, exposure-end and acknowledgement events into trigger, stamp
// and timer-compare commands, with optional mid-exposure compensation.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Content
//  s_*       in         s_tvalid / s_tready  one event per beat
//  m_*       out        m_tvalid / m_tready  one result per event beat
//  cfg_*     in         cfg_wr_en            register write, no read-back
//
// Most events go from the input register to the output register when the
// output is free, so one event can be taken every cycle unless the output
// stalls or a conversion runs. A primary exposure end with compensation
// enabled and a valid exposure waits in the input register while the
// exposure-to-ticks conversion runs, a five-step chain of multipliers
// (product, reciprocal partial products, estimate, back-multiply, correction).
// Reset is asynchronous and active low; it clears all sequencer state and
// loads the register reset values. When the output beat is not taken, the
// input register holds its event and s_tready falls once it is occupied.
//
`default_nettype none

module exposure_compensated_camera_trigger
    import ecct_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // Event stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [31:0] now_us, [32] overflow_seen, [33] init_ok, [39:34] zero
    input  wire logic [39:0]  s_tdata,
    // [2:0] action
    input  wire logic [2:0]   s_tuser,
    // Result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [0] fire_trigger, [1] long_pulse, [2] capture_stamp, [3] compare_write,
    // [19:4] compare_value, [20] clear_overflow, [21] spurious_warning,
    // [53:22] image_count, [85:54] exposure_primary_us,
    // [117:86] exposure_secondary_us, [118] compensating_now, [119] zero
    output logic [119:0]      m_tdata,
    // Configuration writes
    input  wire logic         cfg_wr_en,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [CFG_W-1:0] cfg_wr_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                comp_en_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [TPS_W-1:0]    tps_reg;
    logic [MAXEXP_W-1:0] max_exp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comp_en_reg <= RST_COMP_EN;
            period_reg  <= RST_PERIOD;
            tps_reg     <= RST_TICK_RATE;
            max_exp_reg <= RST_MAX_EXP;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_COMP_EN:   comp_en_reg <= cfg_wr_data[0];
                REG_PERIOD:    period_reg  <= cfg_wr_data[PERIOD_W-1:0];
                REG_TICK_RATE: tps_reg     <= cfg_wr_data[TPS_W-1:0];
                REG_MAX_EXP:   max_exp_reg <= cfg_wr_data[MAXEXP_W-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic        in_valid_reg;
    action_t     in_action_reg;
    logic [31:0] in_now_reg;
    logic        in_ovf_reg;
    logic        in_ok_reg;
    logic        commit;
    logic        out_free;

    assign s_tready = !in_valid_reg || commit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (commit)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_action_reg <= action_t'(s_tuser);
            in_now_reg    <= s_tdata[31:0];
            in_ovf_reg    <= s_tdata[32];
            in_ok_reg     <= s_tdata[33];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    logic [1:0]         ack_count_reg,    ack_count_next;
    logic               armed_reg,        armed_next;
    logic               compensating_reg, compensating_next;
    logic               exposing_reg,     exposing_next;
    logic [31:0]        images_reg,       images_next;
    logic [31:0]        exp_start_reg,    exp_start_next;
    logic [DELAY_W-1:0] delay_reg,        delay_next;
    logic [31:0]        prim_exp_reg,     prim_exp_next;
    logic [31:0]        sec_exp_reg,      sec_exp_next;

    // Exposure measured against the last timer trigger; wraps with the time base.
    logic [31:0] exposure;
    logic        exposure_bad;
    logic        needs_div;

    assign exposure     = in_now_reg - exp_start_reg;
    assign exposure_bad = (exposure == 32'd0) || (exposure >= {12'd0, max_exp_reg});
    assign needs_div    = (in_action_reg == ACT_PRIMARY_END) && comp_en_reg && !exposure_bad;

    // ------------------------------------------------------------------
    // Exposure to delay ticks. The chain runs freely on the held event; the
    // sequencer only counts the steps until the quotient is settled.
    // x = floor(exposure * rate / 128); q0 = floor(x * RECIP / 2^40) is
    // low by at most one, which the remainder check puts right.
    // ------------------------------------------------------------------
    div_state_t div_state_reg, div_state_next;
    logic       div_ready;

    logic [PROD_W-1:0]  prod_reg;
    logic [X_W-1:0]     x_reg;
    logic [PROD_W-1:0]  part_hi_reg;
    logic [PROD_W-1:0]  part_lo_reg;
    logic [DELAY_W-1:0] q0_reg;
    logic [X_W-1:0]     back_reg;
    logic [DELAY_W-1:0] quot_reg;
    logic [PROD_W:0]    est_sum;
    logic [X_W-1:0]     remainder;

    assign est_sum   = (PROD_W+1)'(part_hi_reg) + (PROD_W+1)'(part_lo_reg[PROD_W-1:HALF_W]);
    assign remainder = x_reg - back_reg;

    always_ff @(posedge clk)
    begin
        prod_reg    <= PROD_W'(exposure[MAXEXP_W-1:0]) * PROD_W'(tps_reg);
        x_reg       <= prod_reg[PROD_W-1:PRE_SHIFT];
        part_hi_reg <= PROD_W'(prod_reg[PROD_W-1:PRE_SHIFT+HALF_W]) * PROD_W'(DIV_RECIP);
        part_lo_reg <= PROD_W'(prod_reg[PRE_SHIFT+HALF_W-1:PRE_SHIFT]) * PROD_W'(DIV_RECIP);
        q0_reg      <= est_sum[HALF_W+DELAY_W-1:HALF_W];
        back_reg    <= X_W'(q0_reg) * X_W'(DIV_ODD);
        quot_reg    <= q0_reg + DELAY_W'(remainder >= X_W'(DIV_ODD));
    end

    always_comb
    begin
        div_state_next = div_state_reg;
        unique case (div_state_reg)
            DIV_IDLE:  if (in_valid_reg && needs_div) div_state_next = DIV_PROD;
            DIV_PROD:  div_state_next = DIV_PART;
            DIV_PART:  div_state_next = DIV_EST;
            DIV_EST:   div_state_next = DIV_CHECK;
            DIV_CHECK: div_state_next = DIV_DONE;
            DIV_DONE:  if (out_free) div_state_next = DIV_IDLE;
            default:   div_state_next = DIV_IDLE;
        endcase
    end

    always_comb
    begin
        div_ready = (div_state_reg == DIV_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_state_reg <= DIV_IDLE;
        end
        else
        begin
            div_state_reg <= div_state_next;
        end
    end

    // ------------------------------------------------------------------
    // Event decode: next state and result for the held event
    // ------------------------------------------------------------------
    logic                res_fire, res_long, res_cap, res_cw, res_clr, res_warn;
    logic [PERIOD_W-1:0] res_cv;
    logic [DELAY_W-1:0]  delay_less_one;
    logic [PERIOD_W-1:0] mid_compare;

    assign delay_less_one = delay_reg - DELAY_W'(1);
    assign mid_compare = (|delay_less_one[DELAY_W-1:PERIOD_W]) ? {PERIOD_W{1'b1}}
                                                               : delay_less_one[PERIOD_W-1:0];

    always_comb
    begin
        ack_count_next    = ack_count_reg;
        armed_next        = armed_reg;
        compensating_next = compensating_reg;
        exposing_next     = exposing_reg;
        images_next       = images_reg;
        exp_start_next    = exp_start_reg;
        delay_next        = delay_reg;
        prim_exp_next     = prim_exp_reg;
        sec_exp_next      = sec_exp_reg;
        res_fire          = 1'b0;
        res_long          = 1'b0;
        res_cap           = 1'b0;
        res_cw            = 1'b0;
        res_cv            = '0;
        res_clr           = 1'b0;
        res_warn          = 1'b0;

        unique case (in_action_reg)
            ACT_TIMER:
            begin
                if (!in_ovf_reg)
                begin
                    res_warn = 1'b1;
                end
                else if (armed_reg)
                begin
                    if (comp_en_reg && compensating_reg)
                    begin
                        if (!exposing_reg)
                        begin
                            // Early trigger; the stamp follows at mid-exposure.
                            exposing_next  = 1'b1;
                            res_fire       = 1'b1;
                            exp_start_next = in_now_reg;
                            images_next    = images_reg + 32'd1;
                            res_cw         = 1'b1;
                            res_cv         = (delay_reg != '0) ? mid_compare : period_reg;
                        end
                        else
                        begin
                            res_cap           = 1'b1;
                            compensating_next = 1'b0;
                            res_cw            = 1'b1;
                            res_cv            = period_reg;
                        end
                    end
                    else
                    begin
                        exposing_next  = 1'b1;
                        res_fire       = 1'b1;
                        res_cap        = 1'b1;
                        exp_start_next = in_now_reg;
                        images_next    = images_reg + 32'd1;
                        res_cw         = 1'b1;
                        res_cv         = period_reg;
                    end
                    res_clr = 1'b1;
                end
            end
            ACT_PRIMARY_END:
            begin
                prim_exp_next = exposure;
                if (comp_en_reg)
                begin
                    if (exposure_bad)
                    begin
                        delay_next        = '0;
                        compensating_next = 1'b0;
                    end
                    else
                    begin
                        delay_next        = quot_reg;
                        compensating_next = 1'b1;
                    end
                    res_cw = 1'b1;
                    // Period less delay, floored at zero.
                    res_cv = (DELAY_W'(period_reg) > delay_next)
                           ? period_reg - delay_next[PERIOD_W-1:0] : '0;
                    exposing_next = 1'b0;
                end
            end
            ACT_SECONDARY_END:
            begin
                sec_exp_next = exposure;
            end
            ACT_INIT:
            begin
                if (in_ok_reg && (ack_count_reg != 2'd3))
                begin
                    ack_count_next = ack_count_reg + 2'd1;
                end
                if (ack_count_next == 2'd2)
                begin
                    armed_next = 1'b1;
                end
            end
            ACT_INITIAL_TRIGGER:
            begin
                res_fire    = 1'b1;
                res_long    = 1'b1;
                res_cap     = 1'b1;
                images_next = images_reg + 32'd1;
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Commit and output register
    // ------------------------------------------------------------------
    logic out_valid_reg;

    assign out_free = !out_valid_reg || m_tready;
    assign commit   = in_valid_reg && out_free && (!needs_div || div_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_count_reg    <= '0;
            armed_reg        <= 1'b0;
            compensating_reg <= 1'b0;
            exposing_reg     <= 1'b0;
            images_reg       <= '0;
            exp_start_reg    <= '0;
            delay_reg        <= '0;
            prim_exp_reg     <= '0;
            sec_exp_reg      <= '0;
        end
        else if (commit)
        begin
            ack_count_reg    <= ack_count_next;
            armed_reg        <= armed_next;
            compensating_reg <= compensating_next;
            exposing_reg     <= exposing_next;
            images_reg       <= images_next;
            exp_start_reg    <= exp_start_next;
            delay_reg        <= delay_next;
            prim_exp_reg     <= prim_exp_next;
            sec_exp_reg      <= sec_exp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    logic                out_fire_reg, out_long_reg, out_cap_reg, out_cw_reg;
    logic                out_clr_reg, out_warn_reg, out_comp_reg;
    logic [PERIOD_W-1:0] out_cv_reg;
    logic [31:0]         out_images_reg, out_prim_reg, out_sec_reg;

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_fire_reg   <= res_fire;
            out_long_reg   <= res_long;
            out_cap_reg    <= res_cap;
            out_cw_reg     <= res_cw;
            out_cv_reg     <= res_cv;
            out_clr_reg    <= res_clr;
            out_warn_reg   <= res_warn;
            out_images_reg <= images_next;
            out_prim_reg   <= prim_exp_next;
            out_sec_reg    <= sec_exp_next;
            out_comp_reg   <= compensating_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_comp_reg, out_sec_reg, out_prim_reg, out_images_reg,
                       out_warn_reg, out_clr_reg, out_cv_reg, out_cw_reg, out_cap_reg,
                       out_long_reg, out_fire_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The conversion only runs on an event held in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (div_state_reg != DIV_IDLE) |-> in_valid_reg)
        else $error("conversion running without a held event");

    // Every trigger but the initial one reloads the timer compare.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_fire_reg && !out_long_reg) |-> out_cw_reg)
        else $error("periodic trigger without compare reload");

    // Once armed, the sequencer stays armed until reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(armed_reg))
        else $error("armed flag dropped");

    // A held event whose results are committed frees the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (commit && !s_tvalid) |=> !in_valid_reg)
        else $error("input register not freed after commit");

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking regression for the camera trigger sequencer
// Events go in on the slave stream and results come back on the master
// stream. A model inside this module predicts every result.
// The run has a short directed part, then well-formed trigger frames mixed
// with random noise, under several register settings and idling patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
    import ecct_pkg::*;
;

    // The timer tick rate is turned into delay ticks for half the exposure,
    // hence the division by two million.
    localparam logic [63:0] HALF_EXPOSURE_DIVISOR = 64'd2000000;
    // Codes 5 to 7 of the action field are not used by the sequencer.
    localparam logic [2:0]  ACT_UNUSED_FIRST      = 3'd5;
    localparam logic [2:0]  ACT_UNUSED_LAST       = 3'd7;
    localparam int          RANDOM_PER_SEGMENT    = 210;
    localparam int          SEGMENTS              = 6;
    localparam int          CYCLE_LIMIT           = 400000;
    localparam int          END_PAUSE             = 20;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] now_us;
        logic        overflow_seen;
        logic        init_ok;
    } trig_event_t;

    typedef struct packed {
        logic        fire_trigger;
        logic        long_pulse;
        logic        capture_stamp;
        logic        compare_write;
        logic [15:0] compare_value;
        logic        clear_overflow;
        logic        spurious_warning;
        logic [31:0] image_count;
        logic [31:0] exposure_primary_us;
        logic [31:0] exposure_secondary_us;
        logic        compensating_now;
    } trig_result_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports. Every input is known from time zero.
    // ------------------------------------------------------------------------
    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [39:0]  s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [119:0] m_tdata;
    logic         cfg_wr_en = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [CFG_W-1:0] cfg_wr_data = '0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    exposure_compensated_camera_trigger dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    // ------------------------------------------------------------------------
    // Shadow of the registers and of the sequencer state.
    // The register copy is only changed while nothing is in flight, so the
    // model always sees the same settings as the block did for each event.
    // ------------------------------------------------------------------------
    logic                cfg_comp_en = RST_COMP_EN;
    logic [PERIOD_W-1:0] cfg_period  = RST_PERIOD;
    logic [TPS_W-1:0]    cfg_tps     = RST_TICK_RATE;
    logic [MAXEXP_W-1:0] cfg_max_exp = RST_MAX_EXP;

    logic [1:0]  ack_cnt = '0;
    logic        armed = 1'b0;
    logic        compensating = 1'b0;
    logic        exposing = 1'b0;
    logic [31:0] images = '0;
    logic [31:0] exposure_start = '0;
    logic [31:0] delay_ticks = '0;
    logic [31:0] primary_exposure = '0;
    logic [31:0] secondary_exposure = '0;

    trig_event_t  pending_events[$];
    trig_result_t expected_results[$];
    trig_event_t  drv_event = '0;

    int  events_queued = 0;
    int  events_taken = 0;
    int  results_seen = 0;
    int  failures = 0;
    int  cycle_count = 0;
    int  segment_items = 0;
    int  settings_applied = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  in_beat_taken = 1'b0;
    logic [31:0] gen_time_us = '0;

    // Works out the result of one event and moves the shadow state on.
    function automatic trig_result_t step_sequencer(input trig_event_t ev);
        trig_result_t res;
        logic [31:0]  exposure;
        logic [31:0]  delay_less_one;
        logic [63:0]  product;
        res = '0;
        case (ev.action)
            ACT_TIMER:
            begin
                if (!ev.overflow_seen)
                begin
                    res.spurious_warning = 1'b1;
                end
                else if (armed)
                begin
                    if (cfg_comp_en && compensating)
                    begin
                        if (!exposing)
                        begin
                            // Early trigger; the next compare lands mid-exposure.
                            exposing = 1'b1;
                            res.fire_trigger = 1'b1;
                            exposure_start = ev.now_us;
                            images = images + 32'd1;
                            res.compare_write = 1'b1;
                            delay_less_one = delay_ticks - 32'd1;
                            if (delay_ticks == 32'd0)
                                res.compare_value = cfg_period;
                            else if (delay_less_one > 32'd65535)
                                res.compare_value = 16'hFFFF;
                            else
                                res.compare_value = delay_less_one[15:0];
                        end
                        else
                        begin
                            // Mid-exposure: stamp now and fall back to the period.
                            res.capture_stamp = 1'b1;
                            compensating = 1'b0;
                            res.compare_write = 1'b1;
                            res.compare_value = cfg_period;
                        end
                    end
                    else
                    begin
                        exposing = 1'b1;
                        res.fire_trigger = 1'b1;
                        res.capture_stamp = 1'b1;
                        exposure_start = ev.now_us;
                        images = images + 32'd1;
                        res.compare_write = 1'b1;
                        res.compare_value = cfg_period;
                    end
                    res.clear_overflow = 1'b1;
                end
            end
            ACT_PRIMARY_END:
            begin
                exposure = ev.now_us - exposure_start;
                primary_exposure = exposure;
                if (cfg_comp_en)
                begin
                    if (exposure == 32'd0 || exposure >= {12'd0, cfg_max_exp})
                    begin
                        delay_ticks = 32'd0;
                        compensating = 1'b0;
                    end
                    else
                    begin
                        product = {32'd0, exposure} * {37'd0, cfg_tps};
                        product = product / HALF_EXPOSURE_DIVISOR;
                        delay_ticks = product[31:0];
                        compensating = 1'b1;
                    end
                    res.compare_write = 1'b1;
                    if ({16'd0, cfg_period} > delay_ticks)
                        res.compare_value = cfg_period - delay_ticks[15:0];
                    else
                        res.compare_value = 16'd0;
                    exposing = 1'b0;
                end
            end
            ACT_SECONDARY_END:
            begin
                secondary_exposure = ev.now_us - exposure_start;
            end
            ACT_INIT:
            begin
                if (ev.init_ok && ack_cnt < 2'd3)
                    ack_cnt = ack_cnt + 2'd1;
                if (ack_cnt == 2'd2)
                    armed = 1'b1;
            end
            ACT_INITIAL_TRIGGER:
            begin
                res.fire_trigger = 1'b1;
                res.long_pulse = 1'b1;
                res.capture_stamp = 1'b1;
                images = images + 32'd1;
            end
            default:
            begin
            end
        endcase
        res.image_count = images;
        res.exposure_primary_us = primary_exposure;
        res.exposure_secondary_us = secondary_exposure;
        res.compensating_now = compensating;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver. Inputs move on the falling edge only. A held beat stays on the
    // bus until the rising edge that takes it; only then is the next one
    // fetched, so tvalid is never dropped and raised in the same step.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || in_beat_taken)
            begin
                if (pending_events.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    drv_event = pending_events.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {6'd0, drv_event.init_ok, drv_event.overflow_seen,
                                 drv_event.now_us};
                    s_tuser  <= drv_event.action;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. On each rising edge an accepted event beat is run through the
    // model, and an accepted result beat is checked against the oldest
    // prediction. The cycle limit also lives here.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        trig_result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_results.size());
            $display("exposure_compensated_camera_trigger regression: fail");
            $finish;
        end
        in_beat_taken = 1'b0;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(step_sequencer(drv_event));
                events_taken++;
                in_beat_taken = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result beat 0x%0h arrived with no event waiting", m_tdata);
                    failures++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("fire_trigger", 32'(want.fire_trigger), 32'(m_tdata[0]));
                    check_field("long_pulse", 32'(want.long_pulse), 32'(m_tdata[1]));
                    check_field("capture_stamp", 32'(want.capture_stamp),
                                32'(m_tdata[2]));
                    check_field("compare_write", 32'(want.compare_write),
                                32'(m_tdata[3]));
                    check_field("compare_value", 32'(want.compare_value),
                                32'(m_tdata[19:4]));
                    check_field("clear_overflow", 32'(want.clear_overflow),
                                32'(m_tdata[20]));
                    check_field("spurious_warning", 32'(want.spurious_warning),
                                32'(m_tdata[21]));
                    check_field("image_count", want.image_count, m_tdata[53:22]);
                    check_field("exposure_primary_us", want.exposure_primary_us,
                                m_tdata[85:54]);
                    check_field("exposure_secondary_us", want.exposure_secondary_us,
                                m_tdata[117:86]);
                    check_field("compensating_now", 32'(want.compensating_now),
                                32'(m_tdata[118]));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers, all used from the sequencing block below.
    // ------------------------------------------------------------------------
    task automatic push_event(input logic [2:0] action, input logic [31:0] now_us,
                              input logic ovf, input logic ok);
        trig_event_t ev;
        ev.action = action;
        ev.now_us = now_us;
        ev.overflow_seen = ovf;
        ev.init_ok = ok;
        pending_events.push_back(ev);
        events_queued++;
        segment_items++;
    endtask

    // Every event yields exactly one result, so once every queued event has
    // been taken and answered the block is idle.
    task automatic wait_drained();
        while (events_taken != events_queued || results_seen != events_taken)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        case (idx)
            REG_COMP_EN:   cfg_comp_en = val[0];
            REG_PERIOD:    cfg_period  = val[PERIOD_W-1:0];
            REG_TICK_RATE: cfg_tps     = val[TPS_W-1:0];
            REG_MAX_EXP:   cfg_max_exp = val[MAXEXP_W-1:0];
            default:       ;
        endcase
    endtask

    task automatic apply_settings(input logic comp_en, input logic [15:0] period,
                                  input logic [26:0] tps, input logic [19:0] max_exp);
        wait_drained();
        write_reg(REG_COMP_EN, {26'd0, comp_en});
        write_reg(REG_PERIOD, {11'd0, period});
        write_reg(REG_TICK_RATE, tps);
        write_reg(REG_MAX_EXP, {7'd0, max_exp});
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        settings_applied++;
    endtask

    // One trigger frame as the cameras would produce it: an overflow, often a
    // mid-exposure overflow, the primary exposure end and usually the
    // secondary one. Exposures are mostly valid, sometimes zero or too long.
    task automatic queue_frame();
        logic [31:0] fire_at;
        logic [31:0] exposure;
        int          pick;
        gen_time_us = gen_time_us + $urandom_range(1, 5000);
        if ($urandom_range(0, 9) == 0)
            push_event(ACT_TIMER, gen_time_us, 1'b0, 1'($urandom_range(0, 1)));
        fire_at = gen_time_us;
        push_event(ACT_TIMER, fire_at, 1'b1, 1'($urandom_range(0, 1)));
        pick = $urandom_range(0, 99);
        if (pick < 6)
            exposure = 32'd0;
        else if (pick < 12)
            exposure = {12'd0, cfg_max_exp} + $urandom_range(0, 1000);
        else if (pick < 15)
            exposure = $urandom;
        else if (cfg_max_exp > 20'd1)
            exposure = $urandom_range(1, cfg_max_exp - 1);
        else
            exposure = 32'd1;
        if ($urandom_range(0, 3) != 0)
            push_event(ACT_TIMER, fire_at + (exposure >> 1), 1'b1,
                       1'($urandom_range(0, 1)));
        push_event(ACT_PRIMARY_END, fire_at + exposure, 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
        if ($urandom_range(0, 2) != 0)
            push_event(ACT_SECONDARY_END, fire_at + $urandom_range(0, cfg_max_exp + 100),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        gen_time_us = fire_at + exposure;
    endtask

    // ------------------------------------------------------------------------
    // Sequencing: reset, directed events, then random segments. Every segment
    // but the first starts idle with new register settings; each gets a new
    // idling pattern, and halfway through the sender holds back until every result is in.
    // ------------------------------------------------------------------------
    initial
    begin
        int seg;
        bit paused;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Before arming: an overflow does nothing, a missing one warns.
        push_event(ACT_TIMER, 32'd0, 1'b1, 1'b0);
        push_event(ACT_TIMER, 32'd10, 1'b0, 1'b1);
        // Acknowledgements: a bad one, then enough good ones to saturate.
        push_event(ACT_INIT, 32'd20, 1'b1, 1'b0);
        push_event(ACT_INIT, 32'd30, 1'b0, 1'b1);
        push_event(ACT_INIT, 32'd40, 1'b0, 1'b1);
        push_event(ACT_INIT, 32'd50, 1'b1, 1'b1);
        push_event(ACT_INIT, 32'd60, 1'b0, 1'b1);
        push_event(ACT_INITIAL_TRIGGER, 32'hFFFF_FFFF, 1'b1, 1'b1);
        push_event(ACT_UNUSED_FIRST, 32'hFFFF_FFFF, 1'b1, 1'b1);
        push_event(ACT_UNUSED_LAST, 32'h5A5A_A5A5, 1'b0, 1'b1);
        // Periodic trigger, then a good exposure that turns compensation on.
        push_event(ACT_TIMER, 32'd1000, 1'b1, 1'b0);
        push_event(ACT_SECONDARY_END, 32'd21000, 1'b0, 1'b0);
        push_event(ACT_PRIMARY_END, 32'd21000, 1'b0, 1'b0);
        push_event(ACT_TIMER, 32'd60000, 1'b1, 1'b0);
        push_event(ACT_TIMER, 32'd70000, 1'b1, 1'b0);
        // A zero exposure and one at the maximum both abandon compensation.
        push_event(ACT_PRIMARY_END, 32'd60000, 1'b0, 1'b0);
        push_event(ACT_TIMER, 32'd100000, 1'b1, 1'b0);
        push_event(ACT_PRIMARY_END, 32'd149500, 1'b0, 1'b0);
        // An exposure across the wrap of the microsecond clock.
        push_event(ACT_TIMER, 32'hFFFF_F000, 1'b1, 1'b0);
        push_event(ACT_PRIMARY_END, 32'h0000_1000, 1'b0, 1'b0);
        push_event(ACT_TIMER, 32'h0000_2000, 1'b1, 1'b0);
        push_event(ACT_TIMER, 32'h0000_2800, 1'b1, 1'b0);
        // A one-microsecond exposure gives no delay: the early trigger
        // then reloads the full period.
        push_event(ACT_PRIMARY_END, 32'h0000_2001, 1'b0, 1'b0);
        push_event(ACT_TIMER, 32'h0000_3000, 1'b1, 1'b0);
        push_event(ACT_TIMER, 32'h0000_3400, 1'b1, 1'b0);

        gen_time_us = $urandom;
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg)
                1: apply_settings(1'b1, 16'd65535, 27'd100000000, 20'd1000000);
                2: apply_settings(1'b0, 16'd1, 27'd1, 20'd1);
                3: apply_settings(1'b1, 16'd1, 27'd100000000, 20'd1000000);
                4: apply_settings(1'b1, 16'($urandom_range(1, 65535)),
                                  27'($urandom_range(1, 100000000)),
                                  20'($urandom_range(1, 1000000)));
                5: apply_settings(RST_COMP_EN, RST_PERIOD, RST_TICK_RATE, RST_MAX_EXP);
                default: ;
            endcase
            case (seg % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            segment_items = 0;
            paused = 1'b0;
            while (segment_items < RANDOM_PER_SEGMENT)
            begin
                if (!paused && segment_items >= RANDOM_PER_SEGMENT / 2)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 99) < 85)
                    queue_frame();
                else
                    push_event(3'($urandom_range(0, 7)), $urandom,
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                // Keep the queue short so idling shapes the traffic.
                while (pending_events.size() > 8)
                    @(negedge clk);
            end
        end

        wait_drained();
        repeat (END_PAUSE) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d predicted results never arrived", expected_results.size());
            failures++;
        end
        $display("Ran %0d events and checked %0d results across %0d register settings,",
                 events_taken, results_seen, settings_applied + 1);
        $display("covering periodic, compensating and disabled modes under four idling patterns.");
        if (failures == 0)
            $display("exposure_compensated_camera_trigger regression: pass");
        else
            $display("exposure_compensated_camera_trigger regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/ecct_pkg.sv
rtl/exposure_compensated_camera_trigger.sv
sim/testbench.sv
